// ===== src/srt_pkg.sv =====
package srt_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_CREATED   = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_SEGV      = 3'd4,
        ST_NOT_USER  = 3'd5
    } status_t;

    typedef enum logic {
        OP_CREATE = 1'b0,
        OP_FAULT  = 1'b1
    } opcode_t;

    // item passed from front to back
    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] address;
        logic [32:0] size;
        logic [7:0]  cache_tag;
        logic [31:0] backing_offset;
        logic        not_user;
    } cmd_t;

    // result item
    typedef struct packed {
        status_t     status;
        logic [31:0] region_start;
        logic [32:0] region_size;
        logic [7:0]  region_cache;
        logic [31:0] region_offset;
        logic [7:0]  region_handle;
        logic        hint_hit;
    } result_t;

endpackage

// ===== src/srt_front.sv =====
module srt_front
    import srt_pkg::*;
#(
    parameter int PAGE_SHIFT = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] user_base_mask,
    input  logic        in_valid,
    output logic        in_ready,
    input  opcode_t     in_opcode,
    input  logic [31:0] in_address,
    input  logic [31:0] in_length,
    input  logic [7:0]  in_cache_tag,
    input  logic [31:0] in_backing_offset,
    input  logic        in_user_mode,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

    cmd_t cmd_reg, cmd_next;
    logic valid_reg, valid_next;
    logic [31:0] start;

    // page align creates and classify
    always_comb begin
        start = in_address & ~PAGE_MASK;
        cmd_next = cmd_reg;
        valid_next = valid_reg;
        if (q_ready) valid_next = 1'b0;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            cmd_next.opcode = in_opcode;
            cmd_next.address = (in_opcode == OP_CREATE) ? start : in_address;
            cmd_next.size = {1'b0, in_length} + {1'b0, in_address & PAGE_MASK};
            cmd_next.cache_tag = in_cache_tag;
            cmd_next.backing_offset = in_backing_offset;
            cmd_next.not_user = !in_user_mode && ((in_address & user_base_mask) == 32'd0);
        end
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (!aresetn) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

endmodule

// ===== src/srt_back.sv =====
module srt_back
    import srt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  cmd_t    q_cmd,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    // region table, kept sorted by start
    logic [31:0] e_start_reg  [MAX_REGIONS];
    logic [32:0] e_size_reg   [MAX_REGIONS];
    logic [7:0]  e_cache_reg  [MAX_REGIONS];
    logic [31:0] e_offset_reg [MAX_REGIONS];
    logic [7:0]  e_handle_reg [MAX_REGIONS];
    logic [CW-1:0] count_reg;
    logic [7:0] next_handle_reg, hint_handle_reg;
    logic hint_valid_reg;

    // stage 1: per-entry compare vectors
    logic busy_reg;
    cmd_t cmd_reg;
    logic [MAX_REGIONS-1:0] gt_reg, hit_reg, hmatch_reg;
    logic [MAX_REGIONS-1:0] gt_c, hit_c, hmatch_c;

    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            gt_c[i] = (CW'(i) < count_reg) && (e_start_reg[i] > q_cmd.address);
            hit_c[i] = (CW'(i) < count_reg) && (q_cmd.address >= e_start_reg[i]) &&
                ({1'b0, q_cmd.address} < {1'b0, e_start_reg[i]} + {1'b0, e_size_reg[i]});
            hmatch_c[i] = (CW'(i) < count_reg) && (e_handle_reg[i] == hint_handle_reg);
        end
    end

    logic res_valid_reg;
    result_t res_reg;
    assign q_ready = !busy_reg;
    assign out_valid = res_valid_reg;
    assign out_res = res_reg;

    // stage 2: priority picks
    logic [CW-1:0] pos;
    logic [IW-1:0] hit_idx, hm_idx;
    logic any_hit, any_hm, ovl, ins, hint_ok;
    logic [33:0] new_end, pred_end;
    logic [IW-1:0] sel;
    result_t res_c;

    always_comb begin
        pos = count_reg;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) if (gt_reg[i]) pos = CW'(i);
        hit_idx = '0; any_hit = 1'b0;
        hm_idx = '0; any_hm = 1'b0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin hit_idx = IW'(i); any_hit = 1'b1; end
            if (hmatch_reg[i]) begin hm_idx = IW'(i); any_hm = 1'b1; end
        end
        new_end = {2'b0, cmd_reg.address} + {1'b0, cmd_reg.size};
        ovl = 1'b0;
        if (pos < count_reg)
            ovl = new_end > {2'b0, e_start_reg[IW'(pos)]};
        pred_end = '0;
        if (pos != '0) begin
            pred_end = {2'b0, e_start_reg[IW'(pos - CW'(1))]} +
                       {1'b0, e_size_reg[IW'(pos - CW'(1))]};
            if (pred_end > {2'b0, cmd_reg.address}) ovl = 1'b1;
        end
        hint_ok = hint_valid_reg && any_hm && hit_reg[hm_idx];
        ins = 1'b0;
        res_c = '0;
        sel = hit_idx;
        if (cmd_reg.opcode == OP_CREATE) begin
            if (ovl) res_c.status = ST_OVERLAP;
            else if (count_reg >= CW'(MAX_REGIONS)) res_c.status = ST_FULL;
            else begin
                ins = 1'b1;
                res_c.status = ST_CREATED;
                res_c.region_start = cmd_reg.address;
                res_c.region_size = cmd_reg.size;
                res_c.region_cache = cmd_reg.cache_tag;
                res_c.region_offset = cmd_reg.backing_offset;
                res_c.region_handle = next_handle_reg;
            end
        end else if (cmd_reg.not_user) begin
            res_c.status = ST_NOT_USER;
        end else if (hint_ok || any_hit) begin
            if (hint_ok) sel = hm_idx;
            res_c.status = ST_FOUND;
            res_c.hint_hit = hint_ok;
            res_c.region_start = e_start_reg[sel];
            res_c.region_size = e_size_reg[sel];
            res_c.region_cache = e_cache_reg[sel];
            res_c.region_offset = e_offset_reg[sel];
            res_c.region_handle = e_handle_reg[sel];
        end else begin
            res_c.status = ST_SEGV;
        end
    end

    logic fire2;
    assign fire2 = busy_reg && (!res_valid_reg || out_ready);

    // table shift-insert
    always_ff @(posedge aclk) begin
        if (fire2 && ins) begin
            for (int i = 0; i < MAX_REGIONS; i++) begin
                if (CW'(i) == pos) begin
                    e_start_reg[i] <= cmd_reg.address;
                    e_size_reg[i] <= cmd_reg.size;
                    e_cache_reg[i] <= cmd_reg.cache_tag;
                    e_offset_reg[i] <= cmd_reg.backing_offset;
                    e_handle_reg[i] <= next_handle_reg;
                end else if (i > 0 && CW'(i) > pos) begin
                    e_start_reg[i] <= e_start_reg[i-1];
                    e_size_reg[i] <= e_size_reg[i-1];
                    e_cache_reg[i] <= e_cache_reg[i-1];
                    e_offset_reg[i] <= e_offset_reg[i-1];
                    e_handle_reg[i] <= e_handle_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && !busy_reg) begin
            cmd_reg <= q_cmd;
            gt_reg <= gt_c;
            hit_reg <= hit_c;
            hmatch_reg <= hmatch_c;
        end
        if (fire2) res_reg <= res_c;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg <= '0;
            next_handle_reg <= '0;
            hint_handle_reg <= '0;
            hint_valid_reg <= 1'b0;
        end else begin
            if (q_valid && !busy_reg) busy_reg <= 1'b1;
            else if (fire2) busy_reg <= 1'b0;
            if (fire2) res_valid_reg <= 1'b1;
            else if (out_ready) res_valid_reg <= 1'b0;
            if (fire2 && ins) begin
                count_reg <= count_reg + CW'(1);
                next_handle_reg <= next_handle_reg + 8'd1;
            end
            if (fire2 && cmd_reg.opcode == OP_FAULT && !cmd_reg.not_user &&
                !hint_ok && any_hit) begin
                hint_handle_reg <= e_handle_reg[hit_idx];
                hint_valid_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== src/sorted_region_table_with_lookup_core.sv =====
// Pipeline: the accept edge loads the front register, the compare stage
//   register captures the item once the back part is free, and the
//   select/update stage loads the result register when the output can take it.
// Flow: the back part holds one item through its compare and select stages over
//   the whole region table and takes no new item until its result is loaded.
// Reset (aresetn low, synchronous): table empty, handles and hint cleared,
//   user_base_mask 0x80000000; table contents are not cleared.
module sorted_region_table_with_lookup_core
    import srt_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[0], address[32:1], length[64:33], cache_tag[72:65],
    // backing_offset[104:73], user_mode[105], zero pad
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], region_start[34:3], region_size[67:35], region_cache[75:68],
    // region_offset[107:76], region_handle[115:108], hint_hit[116], zero pad
    output logic [119:0] m_tdata
);

    logic [31:0] mask_reg;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    result_t res;

    // user-space mask register
    always_ff @(posedge aclk) begin
        if (!aresetn) mask_reg <= 32'h8000_0000;
        else if (cfg_wr_en) mask_reg <= cfg_wr_data;
    end

    srt_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .user_base_mask(mask_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_opcode(opcode_t'(s_tdata[0])), .in_address(s_tdata[32:1]),
        .in_length(s_tdata[64:33]), .in_cache_tag(s_tdata[72:65]),
        .in_backing_offset(s_tdata[104:73]), .in_user_mode(s_tdata[105]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    srt_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {3'd0, res.hint_hit, res.region_handle, res.region_offset,
                      res.region_cache, res.region_size, res.region_start, res.status};

endmodule

// ===== verif/sorted_region_table_with_lookup_core_checker.sv =====
`timescale 1ns / 1ps

module sorted_region_table_with_lookup_core_checker
    import srt_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    output int           fail_count,
    output int           pending_count
);

    // predictor state
    logic [31:0] tbl_start [MAX_REGIONS];
    logic [32:0] tbl_size [MAX_REGIONS];
    logic [7:0]  tbl_cache [MAX_REGIONS];
    logic [31:0] tbl_offset [MAX_REGIONS];
    logic [7:0]  tbl_handle [MAX_REGIONS];
    int          tbl_count;
    logic [7:0]  handle_ctr;
    logic [7:0]  hint_handle;
    logic        hint_valid;
    logic [31:0] user_mask;

    result_t expected_results [$];

    initial pending_count = 0;

    function automatic result_t region_result(status_t st, int idx, logic hit);
        result_t r;
        r = '0;
        r.status = st;
        r.region_start = tbl_start[idx];
        r.region_size = tbl_size[idx];
        r.region_cache = tbl_cache[idx];
        r.region_offset = tbl_offset[idx];
        r.region_handle = tbl_handle[idx];
        r.hint_hit = hit;
        return r;
    endfunction

    function automatic logic in_region(int idx, logic [31:0] va);
        return {1'b0, va} >= {1'b0, tbl_start[idx]} &&
               {1'b0, va} < {1'b0, tbl_start[idx]} + tbl_size[idx];
    endfunction

    // compute expected result of one input item and update the table
    function automatic result_t predict_region_op(logic [111:0] item);
        opcode_t     op;
        logic [31:0] va;
        logic [31:0] base;
        logic [32:0] ext;
        logic [33:0] tail;
        int          pos;
        result_t     r;
        op = opcode_t'(item[0]);
        va = item[32:1];
        r = '0;
        if (op == OP_CREATE) begin
            base = va & ~((32'd1 << PAGE_SHIFT) - 1);
            ext = {1'b0, item[64:33]} + {1'b0, va - base};
            pos = tbl_count;
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_start[i] > base) begin
                    pos = i;
                    break;
                end
            end
            tail = {2'b0, base} + {1'b0, ext};
            if (pos < tbl_count && tail > {2'b0, tbl_start[pos]}) begin
                r.status = ST_OVERLAP;
                return r;
            end
            if (pos > 0) begin
                tail = {2'b0, tbl_start[pos-1]} + {1'b0, tbl_size[pos-1]};
                if (tail > {2'b0, base}) begin
                    r.status = ST_OVERLAP;
                    return r;
                end
            end
            if (tbl_count >= MAX_REGIONS) begin
                r.status = ST_FULL;
                return r;
            end
            for (int i = tbl_count; i > pos; i--) begin
                tbl_start[i] = tbl_start[i-1];
                tbl_size[i] = tbl_size[i-1];
                tbl_cache[i] = tbl_cache[i-1];
                tbl_offset[i] = tbl_offset[i-1];
                tbl_handle[i] = tbl_handle[i-1];
            end
            tbl_start[pos] = base;
            tbl_size[pos] = ext;
            tbl_cache[pos] = item[72:65];
            tbl_offset[pos] = item[104:73];
            tbl_handle[pos] = handle_ctr;
            handle_ctr++;
            tbl_count++;
            return region_result(ST_CREATED, pos, 1'b0);
        end
        if (!item[105] && (va & user_mask) == 0) begin
            r.status = ST_NOT_USER;
            return r;
        end
        // last-hit region first
        if (hint_valid) begin
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_handle[i] == hint_handle) begin
                    if (in_region(i, va)) return region_result(ST_FOUND, i, 1'b1);
                    break;
                end
            end
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (in_region(i, va)) begin
                hint_handle = tbl_handle[i];
                hint_valid = 1'b1;
                return region_result(ST_FOUND, i, 1'b0);
            end
        end
        r.status = ST_SEGV;
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            tbl_count = 0;
            handle_ctr = '0;
            hint_handle = '0;
            hint_valid = 1'b0;
            user_mask = 32'h8000_0000;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) user_mask = cfg_wr_data;
            if (s_tvalid && s_tready) expected_results.push_back(predict_region_op(s_tdata));
            if (m_tvalid && m_tready) begin
                got = '0;
                got.status = status_t'(m_tdata[2:0]);
                got.region_start = m_tdata[34:3];
                got.region_size = m_tdata[67:35];
                got.region_cache = m_tdata[75:68];
                got.region_offset = m_tdata[107:76];
                got.region_handle = m_tdata[115:108];
                got.hint_hit = m_tdata[116];
                if (expected_results.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want || m_tdata[119:117] != 3'b0) begin
                        fail_count <= fail_count + 1;
                        if (got.status != want.status)
                            $error("status exp %0d got %0d", want.status, got.status);
                        if (got.region_start != want.region_start)
                            $error("region_start exp %h got %h",
                                   want.region_start, got.region_start);
                        if (got.region_size != want.region_size)
                            $error("region_size exp %h got %h",
                                   want.region_size, got.region_size);
                        if (got.region_cache != want.region_cache)
                            $error("region_cache exp %h got %h",
                                   want.region_cache, got.region_cache);
                        if (got.region_offset != want.region_offset)
                            $error("region_offset exp %h got %h",
                                   want.region_offset, got.region_offset);
                        if (got.region_handle != want.region_handle)
                            $error("region_handle exp %h got %h",
                                   want.region_handle, got.region_handle);
                        if (got.hint_hit != want.hint_hit)
                            $error("hint_hit exp %0d got %0d", want.hint_hit, got.hint_hit);
                        if (m_tdata[119:117] != 3'b0)
                            $error("pad exp 0 got %0d", m_tdata[119:117]);
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== verif/sorted_region_table_with_lookup_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_region_table_with_lookup_core_tb;
    import srt_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    int           fail_count;
    int           pending_count;

    int           send_idle_pct;
    int           stall_pct;
    int           hold_cycles;

    // regions requested so far, used to aim lookups
    logic [31:0]  known_base [$];
    logic [31:0]  known_len [$];

    sorted_region_table_with_lookup_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sorted_region_table_with_lookup_core_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("sorted_region_table_with_lookup_core regression: fail");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [111:0] pack_item(opcode_t op, logic [31:0] addr,
                                               logic [31:0] len, logic [7:0] tag,
                                               logic [31:0] offs, logic umode);
        return {6'b0, umode, offs, tag, len, addr, op};
    endfunction

    // offer one item, honoring sender idle rate
    task automatic send_item(logic [111:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_create(logic [31:0] addr, logic [31:0] len);
        known_base.push_back(addr);
        known_len.push_back(len);
        send_item(pack_item(OP_CREATE, addr, len, 8'($urandom), $urandom, 1'($urandom)));
    endtask

    task automatic send_fault(logic [31:0] addr, logic umode);
        send_item(pack_item(OP_FAULT, addr, $urandom, 8'($urandom), $urandom, umode));
    endtask

    // lookup near a known region: inside, at its edges, or random
    task automatic send_aimed_fault();
        int k;
        logic [31:0] a;
        if (known_base.size() == 0 || $urandom_range(9) == 0) begin
            a = $urandom;
        end else begin
            k = $urandom_range(known_base.size() - 1);
            case ($urandom_range(3))
                0: a = known_base[k];
                1: a = known_base[k] + known_len[k];
                2: a = known_base[k] + known_len[k] - 1;
                default: a = known_base[k] + $urandom_range(known_len[k]);
            endcase
        end
        send_fault(a, $urandom_range(3) != 0);
    endtask

    // wait for all results, then idle to let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mask(logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one random phase of creates and lookups
    task automatic random_phase(int n, int idle, int stall);
        logic [31:0] a;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                a = $urandom;
                if ($urandom_range(1)) a = a & 32'hFFFF_0000;
                send_create(a, ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000));
            end else begin
                send_aimed_fault();
            end
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first region, neighbors, overlaps, zero size, extremes
        send_fault(32'h8000_1000, 1'b0);
        send_fault(32'h0000_1000, 1'b0);
        send_fault(32'h0000_1000, 1'b1);
        send_create(32'h0001_0123, 32'h0000_0100);
        send_create(32'h0003_0000, 32'h0000_1000);
        send_create(32'h0002_0000, 32'h0001_0000);
        send_create(32'h0002_0000, 32'h0000_0001);
        send_create(32'h0000_0000, 32'h0000_1000);
        send_create(32'h0004_0000, 32'h0000_0000);
        send_create(32'h0004_0000, 32'h0000_1000);
        send_create(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_create(32'h0002_FFFF, 32'h0000_0010);
        send_fault(32'h0001_0000, 1'b1);
        send_fault(32'h0001_0000, 1'b1);
        send_fault(32'h0003_0FFF, 1'b1);
        send_fault(32'h0001_0223, 1'b1);
        send_fault(32'hFFFF_FFFF, 1'b0);
        send_fault(32'h0004_0000, 1'b1);
        send_fault(32'h0002_FFFF, 1'b1);
        drain();

        // mask extremes and random values
        write_mask(32'h0000_0000);
        send_fault(32'hFFFF_FFFF, 1'b0);
        send_fault(32'h0003_0000, 1'b1);
        drain();
        write_mask(32'hFFFF_FFFF);
        random_phase(120, 0, 0);

        // long hold-off so the block backs up
        hold_cycles = 300;
        random_phase(40, 0, 0);

        write_mask($urandom);
        random_phase(110, 85, 0);
        write_mask(32'h8000_0000);
        random_phase(110, 0, 85);
        write_mask($urandom);
        random_phase(110, 8, 8);

        if (fail_count == 0) begin
            $display("sorted_region_table_with_lookup_core regression: pass");
        end else begin
            $display("sorted_region_table_with_lookup_core regression: fail");
        end
        $finish;
    end

endmodule
